### sv/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

    localparam int MEM_SIZE  = 65536;
    localparam int MAX_HOLES = 64;
    localparam int IDX_W     = $clog2(MAX_HOLES);
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 17;

    localparam logic       REQ_ALLOC = 1'b0;
    localparam logic       REQ_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic load;
        logic rd_scan;
        logic idx_inc;
        logic save_prev;
        logic wr_trim;
        logic wr_prev;
        logic wr_next;
        logic wr_new;
        logic k_init_erase;
        logic k_init_ins;
        logic rd_k_up;
        logic rd_k_dn;
        logic wr_k_inc;
        logic wr_k_dec;
        logic cnt_inc;
        logic cnt_dec;
        logic set_addr;
        logic set_nofit;
        logic set_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic             is_free;
        logic             bad_req;
        logic             at_end;
        logic             fit;
        logic             len_eq;
        logic             below;
        logic             overlap;
        logic             join_prev;
        logic             join_next;
        logic             full;
        logic             erase_done;
        logic             ins_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage
`default_nettype wire

### sv/ffha_datapath.sv
`default_nettype none
module ffha_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire ffha_pkg::t_cmd          i_cmd,
    output ffha_pkg::t_stat              o_stat,
    input  wire                          i_req_type,
    input  wire [ffha_pkg::LEN_W-1:0]    i_region_size,
    input  wire [ffha_pkg::ADDR_W-1:0]   i_free_address,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [ffha_pkg::ADDR_W-1:0]  o_alloc_address,
    output logic [1:0]                   o_status
);
    localparam int EW = ffha_pkg::ADDR_W + ffha_pkg::LEN_W;
    localparam logic [ffha_pkg::LEN_W-1:0] RST_LEN = ffha_pkg::LEN_W'(ffha_pkg::MEM_SIZE);
    localparam logic [ffha_pkg::CNT_W-1:0] MAXC    = ffha_pkg::CNT_W'(ffha_pkg::MAX_HOLES);

    logic [EW-1:0] r_mem [ffha_pkg::MAX_HOLES];
    logic [EW-1:0] r_rd;
    logic          r_rd_e0;
    logic          r_e0_wr;

    logic                         r_req;
    logic [ffha_pkg::LEN_W-1:0]   r_size;
    logic [ffha_pkg::ADDR_W-1:0]  r_p;
    logic [ffha_pkg::CNT_W-1:0]   r_idx, r_k, r_count;
    logic [ffha_pkg::ADDR_W-1:0]  r_prev_start;
    logic [ffha_pkg::LEN_W-1:0]   r_prev_len;
    logic [ffha_pkg::ADDR_W-1:0]  r_res_addr;
    logic [1:0]                   r_res_st;

    logic [ffha_pkg::ADDR_W-1:0]  rd_start;
    logic [ffha_pkg::LEN_W-1:0]   rd_len;
    logic [ffha_pkg::LEN_W:0]     end_a, prev_end;
    logic                         has_prev, has_next;
    logic                         wr_en, rd_en;
    logic [ffha_pkg::IDX_W-1:0]   wr_addr, rd_addr;
    logic [EW-1:0]                wr_data;
    logic [ffha_pkg::CNT_W-1:0]   idx_m1, k_p1, k_m1;
    logic [ffha_pkg::LEN_W-1:0]   merge_len;

    assign rd_start = r_rd_e0 ? '0      : r_rd[EW-1:ffha_pkg::LEN_W];
    assign rd_len   = r_rd_e0 ? RST_LEN : r_rd[ffha_pkg::LEN_W-1:0];
    assign end_a    = {2'b0, r_p} + {1'b0, r_size};
    assign prev_end = {2'b0, r_prev_start} + {1'b0, r_prev_len};
    assign has_prev = r_idx != '0;
    assign has_next = r_idx < r_count;
    assign idx_m1   = r_idx - 1'b1;
    assign k_p1     = r_k + 1'b1;
    assign k_m1     = r_k - 1'b1;
    assign merge_len = r_prev_len + r_size + (o_stat.join_next ? rd_len : '0);

    always_comb begin
        o_stat.is_free    = r_req == ffha_pkg::REQ_FREE;
        o_stat.bad_req    = (r_size == '0) ||
                            ((r_req == ffha_pkg::REQ_FREE) &&
                             (end_a > (ffha_pkg::LEN_W+1)'(ffha_pkg::MEM_SIZE)));
        o_stat.at_end     = r_idx >= r_count;
        o_stat.fit        = rd_len >= r_size;
        o_stat.len_eq     = rd_len == r_size;
        o_stat.below      = rd_start < r_p;
        o_stat.overlap    = (has_prev && (prev_end > {2'b0, r_p})) ||
                            (has_next && ({2'b0, rd_start} < end_a));
        o_stat.join_prev  = has_prev && (prev_end == {2'b0, r_p});
        o_stat.join_next  = has_next && ({2'b0, rd_start} == end_a);
        o_stat.full       = r_count >= MAXC;
        o_stat.erase_done = k_p1 >= r_count;
        o_stat.ins_done   = r_k <= r_idx;
        o_stat.out_free   = !o_out_valid || i_out_ready;
        o_stat.count      = r_count;
    end

    // single write port: pick address and data by command
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx[ffha_pkg::IDX_W-1:0];
        wr_data = {r_p, r_size};
        if (i_cmd.wr_trim) begin
            wr_data = {rd_start + r_size[ffha_pkg::ADDR_W-1:0], rd_len - r_size};
        end else if (i_cmd.wr_prev) begin
            wr_addr = idx_m1[ffha_pkg::IDX_W-1:0];
            wr_data = {r_prev_start, merge_len};
        end else if (i_cmd.wr_next) begin
            wr_data = {r_p, rd_len + r_size};
        end else if (i_cmd.wr_k_inc || i_cmd.wr_k_dec) begin
            wr_addr = r_k[ffha_pkg::IDX_W-1:0];
            wr_data = {rd_start, rd_len};
        end else if (!i_cmd.wr_new) begin
            wr_en = 1'b0;
        end
    end

    always_comb begin
        rd_en   = i_cmd.rd_scan || i_cmd.rd_k_up || i_cmd.rd_k_dn;
        rd_addr = r_idx[ffha_pkg::IDX_W-1:0];
        if (i_cmd.rd_k_up) begin
            rd_addr = k_p1[ffha_pkg::IDX_W-1:0];
        end else if (i_cmd.rd_k_dn) begin
            rd_addr = k_m1[ffha_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_wr     <= 1'b0;
            r_rd_e0     <= 1'b0;
            r_count     <= ffha_pkg::CNT_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (wr_en && wr_addr == '0) begin
                r_e0_wr <= 1'b1;
            end
            if (rd_en) begin
                r_rd_e0 <= (rd_addr == '0) && !r_e0_wr;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_req_type;
            r_size     <= i_region_size;
            r_p        <= i_free_address;
            r_idx      <= '0;
            r_res_addr <= '0;
            r_res_st   <= ffha_pkg::ST_DONE;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.save_prev) begin
            r_prev_start <= rd_start;
            r_prev_len   <= rd_len;
        end
        if (i_cmd.k_init_erase) begin
            r_k <= r_idx;
        end else if (i_cmd.k_init_ins) begin
            r_k <= r_count;
        end else if (i_cmd.wr_k_inc) begin
            r_k <= k_p1;
        end else if (i_cmd.wr_k_dec) begin
            r_k <= k_m1;
        end
        if (i_cmd.set_addr) begin
            r_res_addr <= rd_start;
        end
        if (i_cmd.set_nofit) begin
            r_res_st <= ffha_pkg::ST_NOFIT;
        end else if (i_cmd.set_full) begin
            r_res_st <= ffha_pkg::ST_FULL;
        end
        if (i_cmd.out_load) begin
            o_alloc_address <= r_res_addr;
            o_status        <= r_res_st;
        end
    end

endmodule
`default_nettype wire

### sv/ffha_ctrl.sv
`default_nettype none
module ffha_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire ffha_pkg::t_stat   i_stat,
    output ffha_pkg::t_cmd         o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_ERD   = 4'd5;
    localparam logic [3:0] S_EWR   = 4'd6;
    localparam logic [3:0] S_IRD   = 4'd7;
    localparam logic [3:0] S_IWR   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state, n_state;

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_stat.bad_req) begin
                    o_cmd.set_nofit = !i_stat.is_free;
                    n_state         = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.at_end) begin
                    if (i_stat.is_free) begin
                        n_state = S_DEC;
                    end else begin
                        o_cmd.set_nofit = 1'b1;
                        n_state         = S_FIN;
                    end
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.is_free) begin
                    if (i_stat.below) begin
                        o_cmd.save_prev = 1'b1;
                        o_cmd.idx_inc   = 1'b1;
                        n_state         = S_RD;
                    end else begin
                        n_state = S_DEC;
                    end
                end else if (i_stat.fit) begin
                    o_cmd.set_addr = 1'b1;
                    if (i_stat.len_eq) begin
                        o_cmd.k_init_erase = 1'b1;
                        n_state            = S_ERD;
                    end else begin
                        o_cmd.wr_trim = 1'b1;
                        n_state       = S_FIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_DEC: begin
                if (i_stat.overlap) begin
                    n_state = S_FIN;
                end else if (i_stat.join_prev) begin
                    o_cmd.wr_prev = 1'b1;
                    if (i_stat.join_next) begin
                        o_cmd.k_init_erase = 1'b1;
                        n_state            = S_ERD;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_stat.join_next) begin
                    o_cmd.wr_next = 1'b1;
                    n_state       = S_FIN;
                end else if (i_stat.full) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.k_init_ins = 1'b1;
                    n_state          = S_IRD;
                end
            end
            S_ERD: begin
                if (i_stat.erase_done) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_k_up = 1'b1;
                    n_state       = S_EWR;
                end
            end
            S_EWR: begin
                o_cmd.wr_k_inc = 1'b1;
                n_state        = S_ERD;
            end
            S_IRD: begin
                if (i_stat.ins_done) begin
                    o_cmd.wr_new  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_k_dn = 1'b1;
                    n_state       = S_IWR;
                end
            end
            S_IWR: begin
                o_cmd.wr_k_dec = 1'b1;
                n_state        = S_IRD;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### sv/first_fit_hole_allocator_core.sv
`default_nettype none
// First-fit hole allocator with coalescing over a 65536-unit space. A table of
// up to 64 free holes, kept in address order in a single-port-write,
// registered-read memory, starts as one hole covering everything. An allocate
// beat (req_type 0) takes the first hole long enough, returns its start and
// trims or removes it; a free beat (req_type 1) merges the region with its
// neighbors or inserts a new hole. Every request beat gives exactly one result
// beat: status 0 done, 1 no hole fits (also a zero-size allocate), 2 table full.
// Zero-size, out-of-range or overlapping frees are dropped with status 0.
// Sequencing: one request at a time. After acceptance a request passes through
// argument checks, then a scan that reads and then compares each table entry
// visited, a decision step for a free, a shift of the entries moved when a
// hole is removed or inserted, and a load of the result register. A zero-size
// or out-of-range request goes straight from the checks to the result load;
// the longest requests insert or remove a hole near the front of a nearly full
// table, and any wait for the output register adds to the time.
// The input is taken only while the controller is idle; a finished result sits
// in the output register, so the next request can be accepted before the
// previous result beat is taken.
module first_fit_hole_allocator_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_req_type,
    input  wire  [16:0] i_region_size,
    input  wire  [15:0] i_free_address,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [15:0] o_alloc_address,
    output logic [1:0]  o_status
);
    ffha_pkg::t_cmd  cmd;
    ffha_pkg::t_stat stat;

    // sequence the scan, the shift loops and the result hand-off
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold the hole table, request registers and output register
    ffha_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_region_size   (i_region_size),
        .i_free_address  (i_free_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status)
    );

    // the table never holds more than its capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= ffha_pkg::CNT_W'(ffha_pkg::MAX_HOLES))
        else $error("hole count exceeds table capacity");

    // an unsuccessful or free result never carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ffha_pkg::ST_DONE) |-> o_alloc_address == '0)
        else $error("address on a failed result");

    // a result beat is loaded only from a finished request
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_in_ready && o_out_valid)
        else $error("result loaded without returning to idle");

endmodule
`default_nettype wire
